// ===== design/ccd_pkg.sv =====
package ccd_pkg;

    localparam int CELL_W  = 7;
    localparam int CHAN_W  = 8;
    localparam int CLASS_W = 4;
    localparam int RUN_W   = 4;
    localparam int HIST_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int MAX_CELLS_DEFAULT   = 128;
    localparam int MAX_HISTORY_DEFAULT = 8;

    localparam logic [HIST_W-1:0] HISTORY_LEN_RESET = 4'd5;
    localparam logic [CHAN_W-1:0] LOW_SAT_RESET     = 8'd40;
    localparam logic [CHAN_W-1:0] BLACK_VALUE_RESET = 8'd50;
    localparam logic [CHAN_W-1:0] WHITE_VALUE_RESET = 8'd200;

    // divider: quotient below 2**QUO_W, two quotient bits per step
    localparam int DIVD_W    = 18;
    localparam int DIVS_W    = 10;
    localparam int QUO_W     = 10;
    localparam int DIV_STEPS = QUO_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int SAT_SCALE = 510;
    localparam int HUE_SCALE = 60;
    localparam int HUE_BIAS  = 301;
    localparam int HUE_WRAP  = 180;

    localparam int HUE_RED_LOW   = 10;
    localparam int HUE_RED_HIGH  = 170;
    localparam int HUE_ORANGE    = 25;
    localparam int HUE_YELLOW    = 35;
    localparam int HUE_GREEN     = 85;
    localparam int HUE_BLUE      = 130;
    localparam int HUE_PURPLE    = 160;

    typedef enum logic [CLASS_W-1:0] {
        CLS_BLACK  = 4'd0,
        CLS_WHITE  = 4'd1,
        CLS_GRAY   = 4'd2,
        CLS_RED    = 4'd3,
        CLS_ORANGE = 4'd4,
        CLS_YELLOW = 4'd5,
        CLS_GREEN  = 4'd6,
        CLS_BLUE   = 4'd7,
        CLS_PURPLE = 4'd8,
        CLS_PINK   = 4'd9,
        CLS_UNSET  = 4'd10
    } class_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HISTORY_LEN = 2'd0,
        CFG_LOW_SAT     = 2'd1,
        CFG_BLACK_VALUE = 2'd2,
        CFG_WHITE_VALUE = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CLASS_W-1:0] last_reading;
        logic [RUN_W-1:0]   run_length;
        logic [CLASS_W-1:0] settled_class;
    } cell_state_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic div_start;
        logic div_sel_hue;
        logic latch_sat;
        logic clear_we;
        logic commit;
    } ccd_cmd_t;

    typedef struct packed {
        logic div_done;
        logic clear_last;
    } ccd_stat_t;

endpackage

// ===== design/cell_color_classify_debounce.sv =====
// Cell color classifier with per-cell debounce.
// Input channel (in_valid/in_ready): cell_index plus average blue, green, red.
// Output channel (out_valid/out_ready): one result transaction per input:
//   cell_number, reading_class, stable_class (10 = unset), stable_changed,
//   window_agrees.
// Config port: cfg_we writes cfg_data to register cfg_index
//   (0 history_len, 1 low_sat_limit, 2 black_value_limit, 3 white_value_limit);
//   the user must write only while no transaction is in flight; the block does not check this.
// One transaction at a time: a new input is taken only once the result of the
// previous one is committed to the output register. The shared divider runs
// saturation and hue one after the other at 2 quotient bits per cycle.
// Reset: config registers return to defaults, then a clearing pass walks the
// cell state memory one entry per cycle, all MAX_CELLS entries, with in_ready low.
// The result sits in an output register; while the receiver stalls the next
// input is still accepted and processed, and it waits for the output register
// to free before its state update and result are committed.
module cell_color_classify_debounce #(
    parameter int MAX_CELLS   = ccd_pkg::MAX_CELLS_DEFAULT,
    parameter int MAX_HISTORY = ccd_pkg::MAX_HISTORY_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ccd_pkg::CELL_W-1:0]          cell_index,
    input  logic [ccd_pkg::CHAN_W-1:0]          blue,
    input  logic [ccd_pkg::CHAN_W-1:0]          green,
    input  logic [ccd_pkg::CHAN_W-1:0]          red,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ccd_pkg::CELL_W-1:0]          cell_number,
    output logic [ccd_pkg::CLASS_W-1:0]         reading_class,
    output logic [ccd_pkg::CLASS_W-1:0]         stable_class,
    output logic                                stable_changed,
    output logic                                window_agrees,
    input  logic                                cfg_we,
    input  logic [ccd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ccd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    ccd_pkg::ccd_cmd_t  cmd;
    ccd_pkg::ccd_stat_t stat;

    ccd_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ccd_datapath #(
        .MAX_CELLS   (MAX_CELLS),
        .MAX_HISTORY (MAX_HISTORY)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cell_index     (cell_index),
        .blue           (blue),
        .green          (green),
        .red            (red),
        .cell_number    (cell_number),
        .reading_class  (reading_class),
        .stable_class   (stable_class),
        .stable_changed (stable_changed),
        .window_agrees  (window_agrees)
    );

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid || out_ready))
        else $error("result committed over an unconsumed result");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction accepted while one is in flight");

    a_div_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !stat.div_done)
        else $error("divider finished too early");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_we |-> (!in_ready && !cmd.commit))
        else $error("activity during clearing pass");

endmodule

// ===== design/ccd_divider.sv =====
module ccd_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ccd_pkg::DIVD_W-1:0]    dividend,
    input  logic [ccd_pkg::DIVS_W-1:0]    divisor,
    output logic                          done,
    output logic [ccd_pkg::QUO_W-1:0]     quotient
);

    localparam int DW = ccd_pkg::DIVS_W;
    localparam int QW = ccd_pkg::QUO_W;

    logic                           busy_reg, busy_next;
    logic [ccd_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DW:0]                    rem_reg, rem_next;
    logic [QW-1:0]                  low_reg, low_next;
    logic [QW-1:0]                  quo_reg, quo_next;

    logic [DW:0] d_ext;
    logic [DW:0] t1, r1, t2, r2;
    logic        ge1, ge2;

    assign d_ext = {1'b0, divisor};
    assign done = busy_reg && (cnt_reg == ccd_pkg::DIV_CNT_W'(ccd_pkg::DIV_STEPS - 1));
    assign quotient = quo_reg;

    always_comb
    begin
        t1 = {rem_reg[DW-1:0], low_reg[QW-1]};
        ge1 = (t1 >= d_ext);
        r1 = ge1 ? (t1 - d_ext) : t1;
        t2 = {r1[DW-1:0], low_reg[QW-2]};
        ge2 = (t2 >= d_ext);
        r2 = ge2 ? (t2 - d_ext) : t2;

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = (DW+1)'(dividend[ccd_pkg::DIVD_W-1:QW]);
            low_next  = dividend[QW-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = r2;
            low_next = {low_reg[QW-3:0], 2'b00};
            quo_next = {quo_reg[QW-3:0], ge1, ge2};
            cnt_next = cnt_reg + 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

endmodule

// ===== design/ccd_datapath.sv =====
module ccd_datapath #(
    parameter int MAX_CELLS   = ccd_pkg::MAX_CELLS_DEFAULT,
    parameter int MAX_HISTORY = ccd_pkg::MAX_HISTORY_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ccd_pkg::ccd_cmd_t                   cmd,
    output ccd_pkg::ccd_stat_t                  stat,
    input  logic                                cfg_we,
    input  logic [ccd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ccd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [ccd_pkg::CELL_W-1:0]          cell_index,
    input  logic [ccd_pkg::CHAN_W-1:0]          blue,
    input  logic [ccd_pkg::CHAN_W-1:0]          green,
    input  logic [ccd_pkg::CHAN_W-1:0]          red,
    output logic [ccd_pkg::CELL_W-1:0]          cell_number,
    output logic [ccd_pkg::CLASS_W-1:0]         reading_class,
    output logic [ccd_pkg::CLASS_W-1:0]         stable_class,
    output logic                                stable_changed,
    output logic                                window_agrees
);

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CW = ccd_pkg::CHAN_W;
    localparam int RW = ccd_pkg::RUN_W;
    localparam int NW = 11;

    // configuration
    logic [ccd_pkg::HIST_W-1:0] hist_len_reg;
    logic [CW-1:0]              low_sat_reg;
    logic [CW-1:0]              black_val_reg;
    logic [CW-1:0]              white_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_len_reg  <= ccd_pkg::HISTORY_LEN_RESET;
            low_sat_reg   <= ccd_pkg::LOW_SAT_RESET;
            black_val_reg <= ccd_pkg::BLACK_VALUE_RESET;
            white_val_reg <= ccd_pkg::WHITE_VALUE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (ccd_pkg::cfg_idx_t'(cfg_index))
                ccd_pkg::CFG_HISTORY_LEN: hist_len_reg  <= cfg_data[ccd_pkg::HIST_W-1:0];
                ccd_pkg::CFG_LOW_SAT:     low_sat_reg   <= cfg_data[CW-1:0];
                ccd_pkg::CFG_BLACK_VALUE: black_val_reg <= cfg_data[CW-1:0];
                ccd_pkg::CFG_WHITE_VALUE: white_val_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // transaction capture
    logic [ccd_pkg::CELL_W-1:0] cell_reg;
    logic [CW-1:0]              b_reg, g_reg, r_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cell_reg <= cell_index;
            b_reg    <= blue;
            g_reg    <= green;
            r_reg    <= red;
        end
    end

    logic          in_range;
    logic [31:0]   cell_ext;
    logic [AW-1:0] cell_addr;

    assign cell_ext  = 32'(cell_reg);
    assign in_range  = (cell_ext < 32'(MAX_CELLS));
    assign cell_addr = cell_ext[AW-1:0];

    // max, min and division operands
    logic [CW-1:0] v_c, mn_c, diff_c;
    logic [NW-1:0] num_c;

    always_comb
    begin
        v_c = r_reg;
        if (g_reg > v_c) v_c = g_reg;
        if (b_reg > v_c) v_c = b_reg;
        mn_c = r_reg;
        if (g_reg < mn_c) mn_c = g_reg;
        if (b_reg < mn_c) mn_c = b_reg;
        diff_c = v_c - mn_c;
        if (v_c == r_reg)
            num_c = NW'(g_reg) + NW'(diff_c) - NW'(b_reg);
        else if (v_c == g_reg)
            num_c = NW'(b_reg) + NW'(3) * NW'(diff_c) - NW'(r_reg);
        else
            num_c = NW'(r_reg) + NW'(5) * NW'(diff_c) - NW'(g_reg);
    end

    logic [CW-1:0]                 v_reg;
    logic                          v_zero_reg, diff_zero_reg;
    logic [ccd_pkg::DIVD_W-1:0]    sat_dvd_reg, hue_dvd_reg;
    logic [ccd_pkg::DIVS_W-1:0]    sat_dvs_reg, hue_dvs_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            v_reg         <= v_c;
            v_zero_reg    <= (v_c == '0);
            diff_zero_reg <= (diff_c == '0);
            sat_dvd_reg   <= ccd_pkg::DIVD_W'(ccd_pkg::SAT_SCALE) * ccd_pkg::DIVD_W'(diff_c)
                             + ccd_pkg::DIVD_W'(v_c);
            sat_dvs_reg   <= ccd_pkg::DIVS_W'({v_c, 1'b0});
            hue_dvd_reg   <= ccd_pkg::DIVD_W'(ccd_pkg::HUE_SCALE) * ccd_pkg::DIVD_W'(num_c)
                             + ccd_pkg::DIVD_W'(ccd_pkg::HUE_BIAS) * ccd_pkg::DIVD_W'(diff_c);
            hue_dvs_reg   <= ccd_pkg::DIVS_W'({diff_c, 1'b0});
        end
    end

    // shared divider
    logic [ccd_pkg::QUO_W-1:0] quo;
    logic                      div_done;

    ccd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cmd.div_sel_hue ? hue_dvd_reg : sat_dvd_reg),
        .divisor  (cmd.div_sel_hue ? hue_dvs_reg : sat_dvs_reg),
        .done     (div_done),
        .quotient (quo)
    );

    logic [CW-1:0] sat_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_sat)
        begin
            sat_reg <= v_zero_reg ? '0 : quo[CW-1:0];
        end
    end

    // classification
    logic [ccd_pkg::QUO_W-1:0] h_wide;
    logic [CW-1:0]             hue;
    ccd_pkg::class_t           cls;

    always_comb
    begin
        h_wide = (quo >= ccd_pkg::QUO_W'(ccd_pkg::HUE_WRAP))
                 ? quo - ccd_pkg::QUO_W'(ccd_pkg::HUE_WRAP) : quo;
        hue = diff_zero_reg ? '0 : h_wide[CW-1:0];
        if (sat_reg < low_sat_reg)
        begin
            if (v_reg < black_val_reg)      cls = ccd_pkg::CLS_BLACK;
            else if (v_reg > white_val_reg) cls = ccd_pkg::CLS_WHITE;
            else                            cls = ccd_pkg::CLS_GRAY;
        end
        else if (hue < CW'(ccd_pkg::HUE_RED_LOW) || hue > CW'(ccd_pkg::HUE_RED_HIGH))
            cls = ccd_pkg::CLS_RED;
        else if (hue < CW'(ccd_pkg::HUE_ORANGE)) cls = ccd_pkg::CLS_ORANGE;
        else if (hue < CW'(ccd_pkg::HUE_YELLOW)) cls = ccd_pkg::CLS_YELLOW;
        else if (hue < CW'(ccd_pkg::HUE_GREEN))  cls = ccd_pkg::CLS_GREEN;
        else if (hue < CW'(ccd_pkg::HUE_BLUE))   cls = ccd_pkg::CLS_BLUE;
        else if (hue < CW'(ccd_pkg::HUE_PURPLE)) cls = ccd_pkg::CLS_PURPLE;
        else                                     cls = ccd_pkg::CLS_PINK;
    end

    // per-cell state store
    ccd_pkg::cell_state_t mem [MAX_CELLS];
    ccd_pkg::cell_state_t rd_reg;
    ccd_pkg::cell_state_t wr_data;
    logic [AW-1:0]        clr_cnt_reg;
    logic [AW-1:0]        wr_addr;
    logic                 wr_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_we)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign stat.clear_last = (clr_cnt_reg == AW'(MAX_CELLS - 1));
    assign stat.div_done   = div_done;

    // debounce update
    logic [RW-1:0]     n_eff;
    logic [RW:0]       run_inc;
    logic [RW-1:0]     run_new;
    logic              agrees;
    logic              changed;
    logic [ccd_pkg::CLASS_W-1:0] settled_new;

    always_comb
    begin
        if (hist_len_reg == '0)
            n_eff = RW'(1);
        else if (32'(hist_len_reg) > 32'(MAX_HISTORY))
            n_eff = RW'(MAX_HISTORY);
        else
            n_eff = RW'(hist_len_reg);
        if (rd_reg.run_length != '0 && rd_reg.last_reading == cls)
            run_inc = {1'b0, rd_reg.run_length} + 1'b1;
        else
            run_inc = (RW+1)'(1);
        run_new = (run_inc > {1'b0, n_eff}) ? n_eff : run_inc[RW-1:0];
        agrees  = (run_new >= n_eff);
        changed = agrees && (rd_reg.settled_class != cls);
        settled_new = changed ? cls : rd_reg.settled_class;
    end

    always_comb
    begin
        if (cmd.clear_we)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '{last_reading: ccd_pkg::CLS_BLACK, run_length: '0,
                        settled_class: ccd_pkg::CLS_UNSET};
        end
        else
        begin
            wr_en   = cmd.commit && in_range;
            wr_addr = cell_addr;
            wr_data = '{last_reading: cls, run_length: run_new, settled_class: settled_new};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.prep)
        begin
            rd_reg <= mem[cell_addr];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            cell_number    <= cell_reg;
            reading_class  <= cls;
            stable_class   <= in_range ? settled_new : ccd_pkg::CLS_UNSET;
            stable_changed <= in_range && changed;
            window_agrees  <= in_range && agrees;
        end
    end

endmodule

// ===== design/ccd_controller.sv =====
module ccd_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ccd_pkg::ccd_stat_t   stat,
    output ccd_pkg::ccd_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_PREP  = 8'b0000_0100,
        ST_SGO   = 8'b0000_1000,
        ST_SDIV  = 8'b0001_0000,
        ST_HGO   = 8'b0010_0000,
        ST_HDIV  = 8'b0100_0000,
        ST_CLASS = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (stat.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid) state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
                state_next = ST_SGO;
            end
            ST_SGO:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_SDIV;
            end
            ST_SDIV:
            begin
                if (stat.div_done) state_next = ST_HGO;
            end
            ST_HGO:
            begin
                cmd.latch_sat   = 1'b1;
                cmd.div_start   = 1'b1;
                cmd.div_sel_hue = 1'b1;
                state_next = ST_HDIV;
            end
            ST_HDIV:
            begin
                cmd.div_sel_hue = 1'b1;
                if (stat.div_done) state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                cmd.commit = slot_free;
                if (slot_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== bench/color_debounce_checker.sv =====
module color_debounce_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [ccd_pkg::CELL_W-1:0]     cell_index,
    input  logic [ccd_pkg::CHAN_W-1:0]     blue,
    input  logic [ccd_pkg::CHAN_W-1:0]     green,
    input  logic [ccd_pkg::CHAN_W-1:0]     red,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [ccd_pkg::CELL_W-1:0]     cell_number,
    input  logic [ccd_pkg::CLASS_W-1:0]    reading_class,
    input  logic [ccd_pkg::CLASS_W-1:0]    stable_class,
    input  logic                           stable_changed,
    input  logic                           window_agrees,
    input  logic                           cfg_we,
    input  logic [ccd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ccd_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ccd_pkg::CELL_W-1:0] cell_id;
        ccd_pkg::class_t            reading;
        ccd_pkg::class_t            settled;
        logic                       changed;
        logic                       agrees;
    } cell_result_t;

    cell_result_t               expected_results [$];
    ccd_pkg::class_t            last_class [ccd_pkg::MAX_CELLS_DEFAULT];
    logic [ccd_pkg::RUN_W-1:0]  run_count [ccd_pkg::MAX_CELLS_DEFAULT];
    ccd_pkg::class_t            settled_class [ccd_pkg::MAX_CELLS_DEFAULT];
    logic [ccd_pkg::HIST_W-1:0] history_len;
    logic [ccd_pkg::CHAN_W-1:0] low_sat;
    logic [ccd_pkg::CHAN_W-1:0] black_limit;
    logic [ccd_pkg::CHAN_W-1:0] white_limit;
    int                         errs = 0;

    function automatic ccd_pkg::class_t classify_color(input logic [ccd_pkg::CHAN_W-1:0] b, g, r);
        int unsigned hi, lo, spread, sat, hue, num;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        spread = hi - lo;
        sat = (hi == 0) ? 0 : (ccd_pkg::SAT_SCALE * spread + hi) / (2 * hi);
        if (spread == 0)
        begin
            hue = 0;
        end
        else
        begin
            // numerator biased by one spread so it stays non-negative
            if (hi == r) num = g + spread - b;
            else if (hi == g) num = b + 3 * spread - r;
            else num = r + 5 * spread - g;
            hue = (ccd_pkg::HUE_SCALE * num + ccd_pkg::HUE_BIAS * spread) / (2 * spread);
            if (hue >= ccd_pkg::HUE_WRAP) hue -= ccd_pkg::HUE_WRAP;
        end
        if (sat < low_sat)
        begin
            if (hi < black_limit) return ccd_pkg::CLS_BLACK;
            if (hi > white_limit) return ccd_pkg::CLS_WHITE;
            return ccd_pkg::CLS_GRAY;
        end
        if (hue < ccd_pkg::HUE_RED_LOW || hue > ccd_pkg::HUE_RED_HIGH) return ccd_pkg::CLS_RED;
        if (hue < ccd_pkg::HUE_ORANGE) return ccd_pkg::CLS_ORANGE;
        if (hue < ccd_pkg::HUE_YELLOW) return ccd_pkg::CLS_YELLOW;
        if (hue < ccd_pkg::HUE_GREEN) return ccd_pkg::CLS_GREEN;
        if (hue < ccd_pkg::HUE_BLUE) return ccd_pkg::CLS_BLUE;
        if (hue < ccd_pkg::HUE_PURPLE) return ccd_pkg::CLS_PURPLE;
        return ccd_pkg::CLS_PINK;
    endfunction

    function automatic cell_result_t debounce_reading(input logic [ccd_pkg::CELL_W-1:0] c,
                                                      input ccd_pkg::class_t cls);
        int unsigned need, run;
        cell_result_t res;
        if (history_len == 0) need = 1;
        else if (history_len > ccd_pkg::MAX_HISTORY_DEFAULT) need = ccd_pkg::MAX_HISTORY_DEFAULT;
        else need = history_len;
        run = run_count[c];
        if (run > 0 && last_class[c] == cls) run++;
        else run = 1;
        if (run > need) run = need;
        run_count[c] = run[ccd_pkg::RUN_W-1:0];
        last_class[c] = cls;
        res.cell_id = c;
        res.reading = cls;
        res.agrees = (run >= need);
        res.changed = 1'b0;
        if (res.agrees && settled_class[c] != cls)
        begin
            settled_class[c] = cls;
            res.changed = 1'b1;
        end
        res.settled = settled_class[c];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ccd_pkg::MAX_CELLS_DEFAULT; i++)
            begin
                last_class[i] = ccd_pkg::CLS_BLACK;
                run_count[i] = '0;
                settled_class[i] = ccd_pkg::CLS_UNSET;
            end
            history_len = ccd_pkg::HISTORY_LEN_RESET;
            low_sat = ccd_pkg::LOW_SAT_RESET;
            black_limit = ccd_pkg::BLACK_VALUE_RESET;
            white_limit = ccd_pkg::WHITE_VALUE_RESET;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ccd_pkg::CFG_HISTORY_LEN: history_len = cfg_data[ccd_pkg::HIST_W-1:0];
                    ccd_pkg::CFG_LOW_SAT:     low_sat = cfg_data;
                    ccd_pkg::CFG_BLACK_VALUE: black_limit = cfg_data;
                    ccd_pkg::CFG_WHITE_VALUE: white_limit = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction for cell %0d with nothing outstanding",
                           cell_number);
                    errs++;
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (cell_number !== want.cell_id)
                    begin
                        $error("cell_number: expected %0d, got %0d", want.cell_id, cell_number);
                        errs++;
                    end
                    if (reading_class !== want.reading)
                    begin
                        $error("reading_class: expected %0d, got %0d",
                               want.reading, reading_class);
                        errs++;
                    end
                    if (stable_class !== want.settled)
                    begin
                        $error("stable_class: expected %0d, got %0d",
                               want.settled, stable_class);
                        errs++;
                    end
                    if (stable_changed !== want.changed)
                    begin
                        $error("stable_changed: expected %0d, got %0d",
                               want.changed, stable_changed);
                        errs++;
                    end
                    if (window_agrees !== want.agrees)
                    begin
                        $error("window_agrees: expected %0d, got %0d",
                               want.agrees, window_agrees);
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results = {expected_results,
                    debounce_reading(cell_index, classify_color(blue, green, red))};
        end
        fail_count <= errs;
        pending <= expected_results.size();
    end

endmodule

// ===== bench/cell_color_classify_debounce_tb.sv =====
module cell_color_classify_debounce_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 122;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [CELL_W-1:0]     cell_index;
    logic [CHAN_W-1:0]     blue;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     red;
    logic                  out_valid;
    logic                  out_ready;
    logic [CELL_W-1:0]     cell_number;
    logic [CLASS_W-1:0]    reading_class;
    logic [CLASS_W-1:0]    stable_class;
    logic                  stable_changed;
    logic                  window_agrees;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    cycle_count;
    int                    burst_left;
    int                    delivered;

    // {blue, green, red}
    logic [23:0] directed_bgr [18] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'h0000FF, 24'h00FF00, 24'hFF0000,
        24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'h0080FF, 24'hFF0080, 24'h5500FF,
        24'h5000FF, 24'hC8D2DC, 24'h313131, 24'h323232, 24'hC8C8C8, 24'hC9C9C9
    };

    // history_len, low_sat_limit, black_value_limit, white_value_limit
    logic [7:0] phase_cfg [5][4] = '{
        '{8'h01, 8'h00, 8'h00, 8'h00},
        '{8'h08, 8'hFF, 8'hFF, 8'hFF},
        '{8'h00, 8'hFF, 8'h00, 8'h00},
        '{8'hFF, 8'h80, 8'h80, 8'h80},
        '{8'hF3, 8'h28, 8'h32, 8'hC8}
    };

    cell_color_classify_debounce DUT (.*);

    color_debounce_checker result_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("TEST FAILED");
        $finish;
    end

    task automatic offer(input logic [CELL_W-1:0] c, input logic [CHAN_W-1:0] b, g, r);
        int gap;
        in_valid <= 1'b1;
        cell_index <= c;
        blue <= b;
        green <= g;
        red <= r;
        do @(posedge clk); while (!in_ready);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] hist, sat, blk, wht);
        cfg_we <= 1'b1;
        cfg_index <= CFG_HISTORY_LEN;
        cfg_data <= hist;
        @(posedge clk);
        cfg_index <= CFG_LOW_SAT;
        cfg_data <= sat;
        @(posedge clk);
        cfg_index <= CFG_BLACK_VALUE;
        cfg_data <= blk;
        @(posedge clk);
        cfg_index <= CFG_WHITE_VALUE;
        cfg_data <= wht;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic pick_color(output logic [CHAN_W-1:0] b, g, r);
        logic [CHAN_W-1:0] ch [3];
        int base, tmp, hi_ch, lo_ch;
        for (int k = 0; k < 3; k++) ch[k] = 8'($urandom);
        case ($urandom_range(0, 2))
            0: ;
            1:
            begin
                base = $urandom_range(0, 255);
                for (int k = 0; k < 3; k++)
                begin
                    tmp = base + int'($urandom_range(0, 24)) - 12;
                    if (tmp < 0) tmp = 0;
                    if (tmp > 255) tmp = 255;
                    ch[k] = tmp[7:0];
                end
            end
            default:
            begin
                hi_ch = $urandom_range(0, 2);
                lo_ch = (hi_ch + $urandom_range(1, 2)) % 3;
                ch[hi_ch] = 8'($urandom_range(160, 255));
                ch[lo_ch] = 8'($urandom_range(0, 30));
            end
        endcase
        b = ch[0];
        g = ch[1];
        r = ch[2];
    endtask

    // mostly runs of one color on one cell, now and then broken by another color
    task automatic run_random(input int count);
        int sent, reps;
        logic [CELL_W-1:0] c;
        logic [CHAN_W-1:0] b, g, r, nb, ng, nr;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 1) != 0) c = 7'($urandom_range(0, 15));
            else c = 7'($urandom_range(0, 127));
            pick_color(b, g, r);
            if ($urandom_range(0, 9) < 7)
            begin
                reps = $urandom_range(2, 10);
                repeat (reps)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        pick_color(nb, ng, nr);
                        offer(c, nb, ng, nr);
                    end
                    else
                    begin
                        offer(c, b, g, r);
                    end
                    sent++;
                end
            end
            else
            begin
                offer(c, b, g, r);
                sent++;
            end
        end
    endtask

    initial
    begin
        int mode, mode_left, stall_left;
        bit long_hold_done;
        out_ready = 1'b0;
        delivered = 0;
        mode = 0;
        mode_left = 0;
        stall_left = 0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) delivered++;
            if (delivered >= 150 && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    default:
                    begin
                        if (stall_left > 0)
                        begin
                            stall_left--;
                            out_ready <= 1'b0;
                        end
                        else if ($urandom_range(0, 7) == 0)
                        begin
                            stall_left = $urandom_range(1, 12);
                            out_ready <= 1'b0;
                        end
                        else
                        begin
                            out_ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cell_index = '0;
        blue = '0;
        green = '0;
        red = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_HISTORY_LEN;
        cfg_data = '0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (!in_ready);

        // reset register values first
        for (int i = 0; i < 18; i++)
            offer((i == 1) ? 7'd127 : 7'(i),
                  directed_bgr[i][23:16], directed_bgr[i][15:8], directed_bgr[i][7:0]);
        repeat (5) offer(7'd9, 8'h00, 8'hFF, 8'h00);
        offer(7'd9, 8'h00, 8'h00, 8'hFF);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 5)
                set_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
            else
                set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            run_random(PHASE_ITEMS);
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
